[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared constants and types for the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int CP_W        = 21;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
   localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO_CP = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI_CP = 21'h00DFFF;

   // Total length of a pending multi-byte sequence
   localparam logic [2:0] SEQ_LEN_2 = 3'd2;
   localparam logic [2:0] SEQ_LEN_3 = 3'd3;
   localparam logic [2:0] SEQ_LEN_4 = 3'd4;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            end_of_text;
   } res_type;

   // One queue entry per accepted byte that gives a result. A replacement
   // for a broken sequence may precede the main result.
   typedef struct packed {
      logic    pre_repl;
      res_type main;
   } entry_type;

   // Queue status seen by the front and back ends
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

[rtl/u8d_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, keeps the partial code point and turns each byte that gives
// a result into a queue entry carrying its results.
// ----------------------------------------------------------------------------
module u8d_front
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              queue_full,
   output logic              push,
   output entry_type         push_entry
);

   typedef struct packed {
      logic            has_res;
      res_type         res;
      logic            start;
      logic [CP_W-1:0] bits;
      logic [2:0]      len;
   } lead_type;

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      remain_ff, remain_in;
   logic [2:0]      len_ff, len_in;
   logic            first_ff, first_in;

   logic            accept;
   logic            is_cont;
   logic            overlong;
   logic [CP_W-1:0] shifted;
   lead_type        ld;

   function automatic lead_type decode_lead(input logic [BYTE_W-1:0] b);
      lead_type r;
      r = '0;
      if (b == '0) begin
         r.has_res           = 1'b1;
         r.res.end_of_text   = 1'b1;
      end else if (!b[7]) begin
         r.has_res           = 1'b1;
         r.res.code_point    = {{(CP_W-BYTE_W){1'b0}}, b};
      end else if (b[7:6] == 2'b10) begin
         r.has_res           = 1'b0;           // stray continuation: drop
      end else if (b[7:5] == 3'b110) begin
         if (b[4:1] == 4'b0000) begin
            r.has_res        = 1'b1;
            r.res.code_point = REPL_CP;
            r.res.malformed  = 1'b1;
         end else begin
            r.start          = 1'b1;
            r.bits           = {{(CP_W-5){1'b0}}, b[4:0]};
            r.len            = SEQ_LEN_2;
         end
      end else if (b[7:4] == 4'b1110) begin
         r.start             = 1'b1;
         r.bits              = {{(CP_W-4){1'b0}}, b[3:0]};
         r.len               = SEQ_LEN_3;
      end else if (b[7:3] == 5'b11110) begin
         r.start             = 1'b1;
         r.bits              = {{(CP_W-3){1'b0}}, b[2:0]};
         r.len               = SEQ_LEN_4;
      end else if (b[7:1] != 7'b1111111) begin
         r.has_res           = 1'b1;           // five- and six-byte leads
         r.res.code_point    = REPL_CP;
         r.res.malformed     = 1'b1;
      end
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_cont   = (req_data_byte[7:6] == 2'b10);
   assign ld        = decode_lead(req_data_byte);
   assign shifted   = {partial_ff[CP_W-7:0], req_data_byte[5:0]};
   assign overlong  = first_ff && (partial_ff == '0) &&
                      (((len_ff == SEQ_LEN_3) && !req_data_byte[5]) ||
                       ((len_ff == SEQ_LEN_4) && (req_data_byte[5:4] == 2'b00)));

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      len_in     = len_ff;
      first_in   = first_ff;
      push       = 1'b0;
      push_entry = '0;
      if (remain_ff != 2'd0) begin
         if (is_cont) begin
            if (overlong) begin
               partial_in                  = '0;
               remain_in                   = 2'd0;
               len_in                      = '0;
               first_in                    = 1'b0;
               push                        = accept;
               push_entry.main.code_point  = REPL_CP;
               push_entry.main.malformed   = 1'b1;
            end else if (remain_ff == 2'd1) begin
               // last continuation: check range and surrogates
               partial_in = '0;
               remain_in  = 2'd0;
               len_in     = '0;
               first_in   = 1'b0;
               push       = accept;
               if ((shifted > MAX_CP) ||
                   ((shifted >= SURR_LO_CP) && (shifted <= SURR_HI_CP))) begin
                  push_entry.main.code_point = REPL_CP;
                  push_entry.main.malformed  = 1'b1;
               end else begin
                  push_entry.main.code_point = shifted;
               end
            end else begin
               partial_in = shifted;
               remain_in  = remain_ff - 2'd1;
               first_in   = 1'b0;
            end
         end else begin
            // missing continuation: replace, then treat the byte as a lead
            push                = accept;
            push_entry.pre_repl = ld.has_res;
            if (ld.has_res) begin
               push_entry.main = ld.res;
            end else begin
               push_entry.main.code_point = REPL_CP;
               push_entry.main.malformed  = 1'b1;
            end
            partial_in = ld.start ? ld.bits : '0;
            len_in     = ld.start ? ld.len : 3'd0;
            remain_in  = ld.start ? 2'(ld.len - 3'd1) : 2'd0;
            first_in   = ld.start;
         end
      end else begin
         push            = accept && ld.has_res;
         push_entry.main = ld.res;
         if (ld.start) begin
            partial_in = ld.bits;
            len_in     = ld.len;
            remain_in  = 2'(ld.len - 3'd1);
            first_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
         len_ff     <= '0;
         first_ff   <= 1'b0;
      end else if (accept) begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         len_ff     <= len_in;
         first_ff   <= first_in;
      end
   end

endmodule

[rtl/u8d_queue.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder entry queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module u8d_queue
   import u8d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output qstat_type stat
);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/u8d_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Drains queue entries into the output register, one result per transaction.
// ----------------------------------------------------------------------------
module u8d_back
   import u8d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  qstat_type       stat,
   input  entry_type       pop_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_malformed,
   output logic            rsp_end_of_text,
   output logic            rsp_run_last
);

   logic    valid_ff, valid_in;
   logic    pend_ff, pend_in;
   res_type pend_res_ff, pend_res_in;
   res_type out_ff, out_in;
   logic    last_ff, last_in;
   logic    load;

   assign load = !valid_ff || rsp_ready;
   assign pop  = load && !pend_ff && !stat.empty;

   always_comb begin
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      pend_res_in = pend_res_ff;
      out_in      = out_ff;
      last_in     = last_ff;
      if (load) begin
         if (pend_ff) begin
            // second result of a split entry
            valid_in = 1'b1;
            out_in   = pend_res_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (!stat.empty) begin
            valid_in = 1'b1;
            if (pop_entry.pre_repl) begin
               out_in.code_point  = REPL_CP;
               out_in.malformed   = 1'b1;
               out_in.end_of_text = 1'b0;
               last_in            = 1'b0;
               pend_in            = 1'b1;
               pend_res_in        = pop_entry.main;
            end else begin
               out_in  = pop_entry.main;
               last_in = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      last_ff     <= last_in;
      pend_res_ff <= pend_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_malformed   = out_ff.malformed;
   assign rsp_end_of_text = out_ff.end_of_text;
   assign rsp_run_last    = last_ff;

endmodule

[rtl/utf8_validating_decoder.sv]
// Each result is written into the queue, then loaded into the output
//   register; the second result of a byte follows the first.
// Throughput: one byte per cycle while the queue is not full; a byte with
//   two results holds the back end longer, absorbed by the four-entry queue.
// Reset: synchronous, clears the decode state, the queue and the output valid.
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes a UTF-8 byte stream into code points, replacing bad input by U+FFFD.
// ----------------------------------------------------------------------------
module utf8_validating_decoder
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_malformed,
   output logic              rsp_end_of_text,
   output logic              rsp_run_last
);

   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type pop_entry;
   qstat_type stat;

   u8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .queue_full    (stat.full),
      .push          (push),
      .push_entry    (push_entry)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .stat       (stat)
   );

   u8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .stat            (stat),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_malformed   (rsp_malformed),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_run_last    (rsp_run_last)
   );

   a_eot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_run_last && !rsp_malformed &&
      (rsp_code_point == '0))
      else $error("terminator result malformed or not last");

   a_repl_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_code_point == REPL_CP)
      else $error("malformed result without replacement value");

   a_not_last_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_malformed && !rsp_end_of_text)
      else $error("leading result of a pair is not a replacement");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("queue written while full");

endmodule
